// File: hw/rtl/bst_pkg.sv
// shared types and constants for the breakpoint slot table
`default_nettype none

package bst_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int SLOT_ID_W       = 8;
  localparam int SLOT_OUT_W      = 5;
  localparam int ADDR_W          = 32;
  localparam int DATA_W          = 8;

  localparam logic [DATA_W-1:0] TRAP_BYTE = 8'hCC;

  typedef enum logic [1:0] {
    MODE_SET      = 2'd0,
    MODE_DEL_ADDR = 2'd1,
    MODE_DEL_SLOT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_ID_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } rd_rsp_t;

  typedef struct packed {
    logic                 en;
    logic                 set;
    logic [SLOT_ID_W-1:0] idx;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    data;
  } wr_req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  mem_write;
    logic [ADDR_W-1:0]     mem_space;
    logic [ADDR_W-1:0]     mem_address;
    logic [DATA_W-1:0]     mem_byte;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bst_store.sv
// slot memory (address and saved byte) with per-slot valid flags
`default_nettype none

module bst_store #(
  parameter int TABLE_SLOTS = bst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bst_pkg::rd_req_t rd,
  input  wire bst_pkg::wr_req_t wr,
  output bst_pkg::rd_rsp_t     rsp
);

  localparam int IdxW = $clog2(TABLE_SLOTS);

  logic [bst_pkg::ADDR_W-1:0] mem_addr [TABLE_SLOTS];
  logic [bst_pkg::DATA_W-1:0] mem_data [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]     valid;

  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;

  assign rd_idx = rd.idx[IdxW-1:0];
  assign wr_idx = wr.idx[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en && wr.set) begin
      mem_addr[wr_idx] <= wr.addr;
      mem_data[wr_idx] <= wr.data;
    end
    if (rd.en) begin
      rsp.addr  <= mem_addr[rd_idx];
      rsp.data  <= mem_data[rd_idx];
      rsp.valid <= valid[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_idx] <= wr.set;
    end
  end

`ifndef SYNTHESIS
  // a write never shares a cycle with a read, so no forwarding is needed
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !rd.en)
    else $error("store read and write in the same cycle");

  a_valid_follows_wr: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> (valid[$past(wr_idx)] == $past(wr.set)))
    else $error("valid flag did not follow write");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bst_ctrl.sv
// command sequencer: scans slots through the memory read port
`default_nettype none

module bst_ctrl #(
  parameter int TABLE_SLOTS = bst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire logic [1:0]                      cmd_mode,
  input  wire logic [bst_pkg::ADDR_W-1:0]      cmd_space,
  input  wire logic [bst_pkg::ADDR_W-1:0]      cmd_addr,
  input  wire logic [bst_pkg::SLOT_ID_W-1:0]   cmd_slot,
  input  wire logic [bst_pkg::DATA_W-1:0]      cmd_orig,
  output bst_pkg::rd_req_t                     rd,
  output bst_pkg::wr_req_t                     wr,
  input  wire bst_pkg::rd_rsp_t                rsp,
  output logic                                 res_valid,
  input  wire logic                            res_take,
  output bst_pkg::result_t                     res
);

  localparam int IdxW = $clog2(TABLE_SLOTS);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_SLOTS - 1);
  localparam logic [bst_pkg::SLOT_OUT_W-1:0] NoSlot = bst_pkg::SLOT_OUT_W'(TABLE_SLOTS);
  localparam logic [bst_pkg::SLOT_ID_W-1:0] SlotLimit = bst_pkg::SLOT_ID_W'(TABLE_SLOTS);

  bst_pkg::state_t state, state_next;

  logic [1:0]                 mode;
  logic [bst_pkg::ADDR_W-1:0] space;
  logic [bst_pkg::ADDR_W-1:0] addr;
  logic [bst_pkg::DATA_W-1:0] orig;
  logic [IdxW-1:0]            scan_idx;
  logic [IdxW-1:0]            last_idx;
  logic                       issued_all;
  logic                       chk_vld;
  logic [IdxW-1:0]            chk_idx;

  logic accept;
  logic slot_ok;
  logic hit;
  logic miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    res_valid  = 1'b0;
    accept     = 1'b0;
    slot_ok    = (cmd_mode == bst_pkg::MODE_SET) || (cmd_mode == bst_pkg::MODE_DEL_ADDR) ||
                 ((cmd_mode == bst_pkg::MODE_DEL_SLOT) && (cmd_slot < SlotLimit));
    hit        = 1'b0;
    miss       = 1'b0;
    rd.en      = 1'b0;
    rd.idx     = bst_pkg::SLOT_ID_W'(scan_idx);
    wr.en      = 1'b0;
    wr.set     = (mode == bst_pkg::MODE_SET);
    wr.idx     = bst_pkg::SLOT_ID_W'(chk_idx);
    wr.addr    = addr;
    wr.data    = orig;
    case (state)
      bst_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          accept     = 1'b1;
          state_next = slot_ok ? bst_pkg::ST_SCAN : bst_pkg::ST_DONE;
        end
      end
      bst_pkg::ST_SCAN: begin
        // set looks for a free slot, deletes for a live one
        if (chk_vld) begin
          if (mode == bst_pkg::MODE_SET) begin
            hit = !rsp.valid;
          end else begin
            hit = rsp.valid && ((mode != bst_pkg::MODE_DEL_ADDR) || (rsp.addr == addr));
          end
        end
        miss  = chk_vld && !hit && (chk_idx == last_idx);
        wr.en = hit;
        rd.en = !issued_all && !hit && !miss;
        if (hit || miss) begin
          state_next = bst_pkg::ST_DONE;
        end
      end
      bst_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = bst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode       <= cmd_mode;
      space      <= cmd_space;
      addr       <= cmd_addr;
      orig       <= cmd_orig;
      issued_all <= 1'b0;
      if (cmd_mode == bst_pkg::MODE_DEL_SLOT) begin
        scan_idx <= cmd_slot[IdxW-1:0];
        last_idx <= cmd_slot[IdxW-1:0];
      end else begin
        scan_idx <= '0;
        last_idx <= LastSlot;
      end
      if (!slot_ok) begin
        res.status      <= bst_pkg::STAT_NONE;
        res.slot_index  <= NoSlot;
        res.mem_write   <= 1'b0;
        res.mem_space   <= '0;
        res.mem_address <= '0;
        res.mem_byte    <= '0;
      end
    end
    if (rd.en) begin
      chk_idx <= scan_idx;
      if (scan_idx == last_idx) begin
        issued_all <= 1'b1;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (hit) begin
      res.status     <= bst_pkg::STAT_DONE;
      res.slot_index <= bst_pkg::SLOT_OUT_W'(chk_idx);
      res.mem_write  <= 1'b1;
      res.mem_space  <= space;
      if (mode == bst_pkg::MODE_SET) begin
        res.mem_address <= addr;
        res.mem_byte    <= bst_pkg::TRAP_BYTE;
      end else begin
        res.mem_address <= rsp.addr;
        res.mem_byte    <= rsp.data;
      end
    end else if (miss) begin
      res.status      <= (mode == bst_pkg::MODE_SET) ? bst_pkg::STAT_FULL : bst_pkg::STAT_NONE;
      res.slot_index  <= NoSlot;
      res.mem_write   <= 1'b0;
      res.mem_space   <= '0;
      res.mem_address <= '0;
      res.mem_byte    <= '0;
    end
  end

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == bst_pkg::ST_IDLE) |-> !chk_vld)
    else $error("stale slot check in idle");

  a_wr_then_done: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> (state == bst_pkg::ST_DONE))
    else $error("slot update without finishing the command");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/breakpoint_slot_table_top.sv
// top level of the breakpoint slot table: sequencer, slot store, result register
//
// Commands are taken one at a time. Set and delete by address walk the slots
// from slot 0 through the single read port of the slot memory, one slot per
// cycle, until a slot fits or the last slot has been checked. Delete by slot
// reads the named slot once. Each slot read is registered in the slot store and
// checked in the controller, whose result register is then loaded into the
// output register; the next command is accepted once the controller is back in
// idle. An out-of-range slot or an unused mode reads no slot and goes straight
// to the result. While the output is stalled with a result in the output
// register, the next command is still taken and worked on; it then waits with
// the input stalled until the output register drains.
// slot_index reports TABLE_SLOTS, masked to 5 bits, when no slot was used.
`default_nettype none

module breakpoint_slot_table_top #(
  parameter int TABLE_SLOTS = bst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    mode,
  input  wire logic [bst_pkg::ADDR_W-1:0]    address_space,
  input  wire logic [bst_pkg::ADDR_W-1:0]    bp_address,
  input  wire logic [bst_pkg::SLOT_ID_W-1:0] slot_id,
  input  wire logic [bst_pkg::DATA_W-1:0]    original_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [bst_pkg::SLOT_OUT_W-1:0]     slot_index,
  output logic                               mem_write,
  output logic [bst_pkg::ADDR_W-1:0]         mem_space,
  output logic [bst_pkg::ADDR_W-1:0]         mem_address,
  output logic [bst_pkg::DATA_W-1:0]         mem_byte
);

  bst_pkg::rd_req_t rd;
  bst_pkg::wr_req_t wr;
  bst_pkg::rd_rsp_t rsp;
  bst_pkg::result_t res;
  bst_pkg::result_t out_q;
  logic             res_valid;
  logic             res_take;

  bst_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (in_valid),
    .cmd_stall (in_stall),
    .cmd_mode  (mode),
    .cmd_space (address_space),
    .cmd_addr  (bp_address),
    .cmd_slot  (slot_id),
    .cmd_orig  (original_byte),
    .rd        (rd),
    .wr        (wr),
    .rsp       (rsp),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  bst_store #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .rd  (rd),
    .wr  (wr),
    .rsp (rsp)
  );

  // load when the register is empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign slot_index  = out_q.slot_index;
  assign mem_write   = out_q.mem_write;
  assign mem_space   = out_q.mem_space;
  assign mem_address = out_q.mem_address;
  assign mem_byte    = out_q.mem_byte;

`ifndef SYNTHESIS
  a_write_means_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mem_write) |-> (status == bst_pkg::STAT_DONE))
    else $error("memory write requested on a failed transaction");
`endif

endmodule

`default_nettype wire
